// ----- rtl/pcc_pkg.sv -----
package pcc_pkg;

    localparam int MAX_COLORS = 256;
    localparam int IDX_BITS   = $clog2(MAX_COLORS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int USAGE_BITS = 32;

    localparam logic [31:0]         OPAQUE_MASK  = 32'hFF00_0000;
    localparam logic [31:0]         OPAQUE_BLACK = 32'hFF00_0000;
    localparam logic [7:0]          NOT_FOUND    = 8'hFF;
    localparam logic [USAGE_BITS-1:0] USAGE_MAX  = '1;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_ADD       = 3'd1;
    localparam logic [2:0] OP_FINISH    = 3'd2;
    localparam logic [2:0] OP_TRANSLATE = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] color;
        logic [7:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  color_count;
        logic [7:0]  found_index;
        logic [31:0] entry_color;
        logic [31:0] entry_usage;
    } t_out_word;

    typedef struct packed {
        logic [31:0]           color;
        logic [USAGE_BITS-1:0] usage;
    } t_entry;

endpackage

// ----- rtl/pcc_table.sv -----
module pcc_table (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [pcc_pkg::IDX_BITS-1:0] i_rd_addr,
    output pcc_pkg::t_entry              o_rd_data,
    input  logic                         i_wr_en,
    input  logic [pcc_pkg::IDX_BITS-1:0] i_wr_addr,
    input  pcc_pkg::t_entry              i_wr_data
);
    import pcc_pkg::*;

    t_entry r_mem [MAX_COLORS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/palette_color_collector.sv -----
// Palette color collector.
// Input channel (i_in_valid / o_in_stall, word i_in_word) takes one command
// word: clear, add pixel, finish and sort, translate color, read entry.
// Every accepted word yields exactly one result word on the output channel
// (o_out_valid / i_out_stall, word o_out_word) holding status, color count
// and the query answers.
// One word is worked on at a time; the input stalls until its result sits in
// the output register. Add pixel scans the entries for a match, bumping its
// count, or appends a new color; translate scans for the color; read entry
// reads one entry; finish runs an insertion sort by usage over the table
// memory, then a two-color fix-up. The table memory has a single registered
// read port and one color and count per entry; each entry visited costs a
// read state and a compare state.
// Reset clears the count and flags; table contents stay undefined and are
// never used beyond the count. A stalled output word holds, and the block
// takes no new word until it has been delivered into the output register.
// i_cfg_we writes fill_alpha; write it only while idle.
module palette_color_collector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pcc_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pcc_pkg::t_out_word o_out_word,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import pcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHK, S_APPEND, S_RDCHK,
        S_SK_RD, S_SK_LD, S_SC_RD, S_SC_CHK, S_SK_WR,
        S_SW, S_SW1, S_SW2, S_SW3, S_RESP
    } t_state;

    t_state                r_state;
    logic [2:0]            r_op;
    t_entry                r_key;
    logic [IDX_BITS-1:0]   r_idx;
    logic [IDX_BITS-1:0]   r_i;
    logic [IDX_BITS-1:0]   r_j;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_overflow;
    logic                  r_sorted;
    logic                  r_fill_alpha;
    logic [7:0]            r_found;
    logic [31:0]           r_ecolor;
    logic [31:0]           r_eusage;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    // table port controls
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    t_entry                rd_data;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    t_entry                wr_data;

    logic                  in_acc;
    logic [CNT_BITS-1:0]   idx_next;
    logic [CNT_BITS-1:0]   i_next;
    logic [31:0]           in_color;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign idx_next    = {1'b0, r_idx} + CNT_BITS'(1);
    assign i_next      = {1'b0, r_i} + CNT_BITS'(1);
    assign in_color    = r_fill_alpha ? (i_in_word.color | OPAQUE_MASK) : i_in_word.color;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    pcc_table u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // read address per state
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            S_SCAN:  begin rd_en = 1'b1; rd_addr = r_idx;             end
            S_SK_RD: begin rd_en = 1'b1; rd_addr = r_i;               end
            S_SC_RD: begin rd_en = 1'b1; rd_addr = r_j - IDX_BITS'(1); end
            S_SW:    begin rd_en = 1'b1; rd_addr = IDX_BITS'(1);      end
            S_SW1:   begin rd_en = 1'b1; rd_addr = '0;                end
            default: ;
        endcase
    end

    // write port per state
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = r_key;
        case (r_state)
            S_CHK: begin
                // bump the count of a matching color on add, saturating
                wr_en         = (r_op == OP_ADD) && (rd_data.color == r_key.color);
                wr_addr       = r_idx;
                wr_data.color = rd_data.color;
                wr_data.usage = (rd_data.usage == USAGE_MAX) ? rd_data.usage
                                                             : rd_data.usage + 1'b1;
            end
            S_APPEND: begin
                wr_en         = (r_count < CNT_BITS'(MAX_COLORS));
                wr_addr       = r_count[IDX_BITS-1:0];
                wr_data.color = r_key.color;
                wr_data.usage = USAGE_BITS'(1);
            end
            S_SC_CHK: begin
                // shift the larger entry up, or drop the key in place
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = (rd_data.usage > r_key.usage) ? rd_data : r_key;
            end
            S_SK_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_key;
            end
            S_SW2: begin
                wr_en   = (r_key.color == OPAQUE_BLACK);
                wr_addr = '0;
                wr_data = r_key;
            end
            S_SW3: begin
                wr_en   = 1'b1;
                wr_addr = IDX_BITS'(1);
                wr_data = rd_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_sorted     <= 1'b0;
            r_fill_alpha <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill_alpha <= i_cfg_wdata;
            end
            // drop a delivered word unless a new one loads this cycle
            if (r_out_valid && !i_out_stall && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op        <= i_in_word.op;
                        r_ecolor    <= '0;
                        r_eusage    <= '0;
                        r_key.usage <= '0;
                        r_idx       <= (i_in_word.op == OP_READ)
                                       ? i_in_word.entry_index[IDX_BITS-1:0] : '0;
                        r_found     <= (i_in_word.op == OP_TRANSLATE) ? NOT_FOUND : '0;
                        case (i_in_word.op)
                            OP_CLEAR: begin
                                r_count    <= '0;
                                r_overflow <= 1'b0;
                                r_sorted   <= 1'b0;
                                r_state    <= S_RESP;
                            end
                            OP_ADD: begin
                                r_key.color <= in_color;
                                if (!r_overflow && !r_sorted) begin
                                    r_state <= (r_count == '0) ? S_APPEND : S_SCAN;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            OP_FINISH: begin
                                r_i <= IDX_BITS'(1);
                                if (!r_overflow && !r_sorted) begin
                                    r_state <= (r_count > CNT_BITS'(1)) ? S_SK_RD : S_SW;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            OP_TRANSLATE: begin
                                r_key.color <= i_in_word.color;
                                if (!r_overflow && r_sorted && r_count != '0) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            OP_READ: begin
                                if (CNT_BITS'(i_in_word.entry_index) < r_count) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end

                S_SCAN: begin
                    r_state <= (r_op == OP_READ) ? S_RDCHK : S_CHK;
                end

                S_RDCHK: begin
                    r_ecolor <= rd_data.color;
                    r_eusage <= rd_data.usage;
                    r_state  <= S_RESP;
                end

                S_CHK: begin
                    if (rd_data.color == r_key.color) begin
                        if (r_op == OP_TRANSLATE) begin
                            r_found <= (r_idx < NOT_FOUND) ? r_idx : NOT_FOUND;
                        end
                        r_state <= S_RESP;
                    end else if (idx_next == r_count) begin
                        r_state <= (r_op == OP_ADD) ? S_APPEND : S_RESP;
                    end else begin
                        r_idx   <= idx_next[IDX_BITS-1:0];
                        r_state <= S_SCAN;
                    end
                end

                S_APPEND: begin
                    if (r_count < CNT_BITS'(MAX_COLORS)) begin
                        r_count <= r_count + CNT_BITS'(1);
                    end else begin
                        r_overflow <= 1'b1;
                    end
                    r_state <= S_RESP;
                end

                S_SK_RD: begin
                    r_state <= S_SK_LD;
                end

                S_SK_LD: begin
                    r_key   <= rd_data;
                    r_j     <= r_i;
                    r_state <= S_SC_RD;
                end

                S_SC_RD: begin
                    r_state <= S_SC_CHK;
                end

                S_SC_CHK: begin
                    if (rd_data.usage > r_key.usage) begin
                        r_j     <= r_j - IDX_BITS'(1);
                        r_state <= (r_j == IDX_BITS'(1)) ? S_SK_WR : S_SC_RD;
                    end else if (i_next == r_count) begin
                        r_state <= S_SW;
                    end else begin
                        r_i     <= i_next[IDX_BITS-1:0];
                        r_state <= S_SK_RD;
                    end
                end

                S_SK_WR: begin
                    if (i_next == r_count) begin
                        r_state <= S_SW;
                    end else begin
                        r_i     <= i_next[IDX_BITS-1:0];
                        r_state <= S_SK_RD;
                    end
                end

                S_SW: begin
                    // two-color fix-up: opaque black goes first
                    if (r_count == CNT_BITS'(2)) begin
                        r_state <= S_SW1;
                    end else begin
                        r_sorted <= 1'b1;
                        r_state  <= S_RESP;
                    end
                end

                S_SW1: begin
                    r_key   <= rd_data;
                    r_state <= S_SW2;
                end

                S_SW2: begin
                    r_state <= (r_key.color == OPAQUE_BLACK) ? S_SW3 : S_RESP;
                    r_sorted <= 1'b1;
                end

                S_SW3: begin
                    r_state <= S_RESP;
                end

                S_RESP: begin
                    // load the output register once it is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid            <= 1'b1;
                        r_out_word.status      <= r_overflow ? ST_OVERFLOW
                                                 : (r_sorted ? ST_OK : ST_PENDING);
                        r_out_word.color_count <= 9'(r_count);
                        r_out_word.found_index <= r_found;
                        r_out_word.entry_color <= r_ecolor;
                        r_out_word.entry_usage <= r_eusage;
                        r_state                <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
